/* sv/owtr_pkg.sv */
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared types for the one-wire temperature reader: timing registers and
// the per-tick result word.
// ----------------------------------------------------------------------------
`default_nettype none

package owtr_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_wait_ticks;
    logic [7:0]  write_setup_ticks;
    logic [7:0]  write_hold_ticks;
    logic [7:0]  read_low_ticks;
    logic [7:0]  read_sample_ticks;
    logic [7:0]  read_recover_ticks;
  } cfg_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence_missing;
    logic [15:0] temperature_raw;
  } res_t;

endpackage

`default_nettype wire

/* sv/owtr_if.sv */
// ----------------------------------------------------------------------------
// owtr_in_if / owtr_out_if
// Valid/ready channels for bus ticks in and per-tick results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface owtr_in_if;
  logic valid;
  logic ready;
  logic line_sample;
  logic start_request;

  modport source (output valid, output line_sample, output start_request, input ready);
  modport sink (input valid, input line_sample, input start_request, output ready);
endinterface

interface owtr_out_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic        presence_missing;
  logic [15:0] temperature_raw;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output presence_missing, output temperature_raw, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input presence_missing, input temperature_raw, output ready);
endinterface

`default_nettype wire

/* sv/owtr_cfg.sv */
// ----------------------------------------------------------------------------
// owtr_cfg
// Slot timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [owtr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [owtr_pkg::CfgDataW-1:0] cfg_wdata,
  output owtr_pkg::cfg_t                     cfg
);
  import owtr_pkg::*;

  typedef enum logic [CfgIdxW-1:0] {
    IDX_RESET_LOW    = 3'd0,
    IDX_PRES_WAIT    = 3'd1,
    IDX_WRITE_SETUP  = 3'd2,
    IDX_WRITE_HOLD   = 3'd3,
    IDX_READ_LOW     = 3'd4,
    IDX_READ_SAMPLE  = 3'd5,
    IDX_READ_RECOVER = 3'd6
  } reg_idx_t;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= 16'd247;
      cfg_r.presence_wait_ticks <= 16'd27;
      cfg_r.write_setup_ticks   <= 8'd5;
      cfg_r.write_hold_ticks    <= 8'd20;
      cfg_r.read_low_ticks      <= 8'd1;
      cfg_r.read_sample_ticks   <= 8'd1;
      cfg_r.read_recover_ticks  <= 8'd17;
    end else if (cfg_we) begin
      case (cfg_index)
        IDX_RESET_LOW:    cfg_r.reset_low_ticks     <= cfg_wdata;
        IDX_PRES_WAIT:    cfg_r.presence_wait_ticks <= cfg_wdata;
        IDX_WRITE_SETUP:  cfg_r.write_setup_ticks   <= cfg_wdata[7:0];
        IDX_WRITE_HOLD:   cfg_r.write_hold_ticks    <= cfg_wdata[7:0];
        IDX_READ_LOW:     cfg_r.read_low_ticks      <= cfg_wdata[7:0];
        IDX_READ_SAMPLE:  cfg_r.read_sample_ticks   <= cfg_wdata[7:0];
        IDX_READ_RECOVER: cfg_r.read_recover_ticks  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* sv/owtr_seq.sv */
// ----------------------------------------------------------------------------
// owtr_seq
// Bus script sequencer: reset/presence, four command bytes across the two
// resets, two read bytes. Advances one bus tick per accepted word.
// ----------------------------------------------------------------------------
`default_nettype none

module owtr_seq (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire logic  line_sample,
  input  wire logic  start_request,
  input  wire owtr_pkg::cfg_t cfg,
  output owtr_pkg::res_t res
);
  import owtr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_HOLD, PH_W_SETUP, PH_W_HOLD,
    PH_R_LOW, PH_R_SAMPLE, PH_R_RECOV, PH_DONE
  } phase_t;

  // script steps
  localparam logic [2:0] StepResetA  = 3'd0;
  localparam logic [2:0] StepSkipA   = 3'd1;
  localparam logic [2:0] StepConvert = 3'd2;
  localparam logic [2:0] StepResetB  = 3'd3;
  localparam logic [2:0] StepSkipB   = 3'd4;
  localparam logic [2:0] StepReadCmd = 3'd5;
  localparam logic [2:0] StepReadLo  = 3'd6;
  localparam logic [2:0] StepReadHi  = 3'd7;

  // bus command bytes
  localparam logic [7:0] CmdSkipRom     = 8'hCC;
  localparam logic [7:0] CmdConvert     = 8'h44;
  localparam logic [7:0] CmdReadScratch = 8'hBE;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] result_r, result_nxt;
  logic        pres_r, pres_nxt;

  logic [15:0] limit;
  logic [15:0] cnt_inc;
  logic        tdone;
  logic        do_begin;
  logic [2:0]  item_sel;
  phase_t      begin_phase;
  logic [7:0]  begin_shift;
  logic [2:0]  bit_inc;
  logic        drive;
  logic        busy;
  logic        done;

  // slot length of the current phase
  always_comb begin
    unique case (phase_r)
      PH_RST_LOW:  limit = cfg.reset_low_ticks;
      PH_RST_WAIT: limit = cfg.presence_wait_ticks;
      PH_W_SETUP:  limit = {8'd0, cfg.write_setup_ticks};
      PH_W_HOLD:   limit = {8'd0, cfg.write_hold_ticks};
      PH_R_LOW:    limit = {8'd0, cfg.read_low_ticks};
      PH_R_SAMPLE: limit = {8'd0, cfg.read_sample_ticks};
      PH_R_RECOV:  limit = {8'd0, cfg.read_recover_ticks};
      default:     limit = 16'd1;
    endcase
  end

  assign cnt_inc = tick_r + 16'd1;
  // a zero register acts as one tick; wrap also ends the slot
  assign tdone   = (cnt_inc >= limit) || (cnt_inc == 16'd0);
  assign bit_inc = bit_r + 3'd1;
  assign item_sel = (phase_r == PH_IDLE) ? StepResetA : cmd_r + 3'd1;

  // script item decode
  always_comb begin
    unique case (item_sel)
      StepResetA, StepResetB: begin
        begin_phase = PH_RST_LOW;
        begin_shift = shift_r;
      end
      StepReadLo, StepReadHi: begin
        begin_phase = PH_R_LOW;
        begin_shift = 8'h00;
      end
      StepSkipA, StepSkipB: begin
        begin_phase = PH_W_SETUP;
        begin_shift = CmdSkipRom;
      end
      StepConvert: begin
        begin_phase = PH_W_SETUP;
        begin_shift = CmdConvert;
      end
      StepReadCmd: begin
        begin_phase = PH_W_SETUP;
        begin_shift = CmdReadScratch;
      end
      default: begin
        begin_phase = PH_IDLE;
        begin_shift = shift_r;
      end
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    bit_nxt    = bit_r;
    tick_nxt   = tick_r;
    shift_nxt  = shift_r;
    low_nxt    = low_r;
    result_nxt = result_r;
    pres_nxt   = pres_r;
    do_begin   = 1'b0;
    drive      = 1'b0;
    busy       = 1'b1;
    done       = 1'b0;

    unique case (phase_r)
      PH_RST_LOW: begin
        drive    = 1'b1;
        tick_nxt = tdone ? 16'd0 : cnt_inc;
        if (tdone) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        tick_nxt = tdone ? 16'd0 : cnt_inc;
        if (tdone) begin
          if (!line_sample) begin
            phase_nxt = PH_RST_HOLD;
          end else begin
            pres_nxt = 1'b1;
            do_begin = 1'b1;
          end
        end
      end
      PH_RST_HOLD: begin
        // wait for the sensor to release the line
        if (line_sample) do_begin = 1'b1;
      end
      PH_W_SETUP: begin
        drive    = 1'b1;
        tick_nxt = tdone ? 16'd0 : cnt_inc;
        if (tdone) phase_nxt = PH_W_HOLD;
      end
      PH_W_HOLD: begin
        drive    = ~shift_r[0];
        tick_nxt = tdone ? 16'd0 : cnt_inc;
        if (tdone) begin
          shift_nxt = {1'b0, shift_r[7:1]};
          bit_nxt   = bit_inc;
          if (bit_inc == 3'd0) do_begin = 1'b1;
          else phase_nxt = PH_W_SETUP;
        end
      end
      PH_R_LOW: begin
        drive    = 1'b1;
        tick_nxt = tdone ? 16'd0 : cnt_inc;
        if (tdone) phase_nxt = PH_R_SAMPLE;
      end
      PH_R_SAMPLE: begin
        tick_nxt = tdone ? 16'd0 : cnt_inc;
        if (tdone) begin
          if (line_sample) shift_nxt[bit_r] = 1'b1;
          phase_nxt = PH_R_RECOV;
        end
      end
      PH_R_RECOV: begin
        tick_nxt = tdone ? 16'd0 : cnt_inc;
        if (tdone) begin
          bit_nxt = bit_inc;
          if (bit_inc != 3'd0) begin
            phase_nxt = PH_R_LOW;
          end else if (cmd_r == StepReadLo) begin
            low_nxt  = shift_r;
            do_begin = 1'b1;
          end else begin
            result_nxt = {shift_r, low_r};
            phase_nxt  = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        busy      = 1'b0;
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        busy      = 1'b0;
        phase_nxt = PH_IDLE;
        if (start_request) begin
          pres_nxt = 1'b0;
          do_begin = 1'b1;
        end
      end
    endcase

    if (do_begin) begin
      cmd_nxt   = item_sel;
      tick_nxt  = 16'd0;
      bit_nxt   = 3'd0;
      phase_nxt = begin_phase;
      shift_nxt = begin_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cmd_r    <= 3'd0;
      bit_r    <= 3'd0;
      tick_r   <= 16'd0;
      shift_r  <= 8'd0;
      low_r    <= 8'd0;
      result_r <= 16'd0;
      pres_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      bit_r    <= bit_nxt;
      tick_r   <= tick_nxt;
      shift_r  <= shift_nxt;
      low_r    <= low_nxt;
      result_r <= result_nxt;
      pres_r   <= pres_nxt;
    end
  end

  always_comb begin
    res.drive_low        = drive;
    res.busy_res         = busy;
    res.done_res         = done;
    res.presence_missing = pres_nxt;
    res.temperature_raw  = result_nxt;
  end

endmodule

`default_nettype wire

/* sv/one_wire_temperature_reader.sv */
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// One-wire master: reset, skip ROM, convert, reset, skip ROM, read
// scratchpad, then two bytes of raw temperature. One word in per bus tick.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  in_ch    in   line_sample, start_request                      valid/ready
//  out_ch   out  drive_low, busy_res, done_res, presence_missing, valid/ready
//                temperature_raw
//  cfg_*    in   cfg_index, cfg_wdata                             cfg_we
//
// Each accepted word is one bus tick and yields one result word; one word
// per cycle is sustained while the output takes its words. The sequencer
// state advances in the accept cycle and the result lands in the output
// register on the same edge. A stalled output holds its word; the input is
// taken again in the cycle the output register drains. Reset is synchronous
// and restores the timing registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module one_wire_temperature_reader (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  owtr_in_if.sink                            in_ch,
  owtr_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [owtr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [owtr_pkg::CfgDataW-1:0] cfg_wdata
);
  import owtr_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_r;
  logic out_valid_r;
  logic step;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  owtr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owtr_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .line_sample   (in_ch.line_sample),
    .start_request (in_ch.start_request),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // load the result word with the tick
  always_ff @(posedge clk) begin
    if (step) out_r <= res;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.drive_low        = out_r.drive_low;
  assign out_ch.busy_res         = out_r.busy_res;
  assign out_ch.done_res         = out_r.done_res;
  assign out_ch.presence_missing = out_r.presence_missing;
  assign out_ch.temperature_raw  = out_r.temperature_raw;

endmodule

`default_nettype wire

/* tb/owtr_tick_checker.sv */
// ----------------------------------------------------------------------------
// owtr_tick_checker
// Watches the tick and result channels of the one-wire temperature reader,
// runs its own copy of the bus sequencer for every accepted tick and compares
// each accepted result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module owtr_tick_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_line_sample,
  input  logic                          in_start_request,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_drive_low,
  input  logic                          out_busy_res,
  input  logic                          out_done_res,
  input  logic                          out_presence_missing,
  input  logic [15:0]                   out_temperature_raw,
  input  logic                          cfg_we,
  input  logic [owtr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [owtr_pkg::CfgDataW-1:0] cfg_wdata,
  output int                            mismatches,
  output int                            pending,
  output int                            words_checked,
  output int                            temps_read,
  output int                            presence_alerts,
  output logic                          seq_idle,
  output logic                          seq_done_tick
);

  // timing register indexes
  localparam logic [owtr_pkg::CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [owtr_pkg::CfgIdxW-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [owtr_pkg::CfgIdxW-1:0] REG_WRITE_SETUP   = 3'd2;
  localparam logic [owtr_pkg::CfgIdxW-1:0] REG_WRITE_HOLD    = 3'd3;
  localparam logic [owtr_pkg::CfgIdxW-1:0] REG_READ_LOW      = 3'd4;
  localparam logic [owtr_pkg::CfgIdxW-1:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [owtr_pkg::CfgIdxW-1:0] REG_READ_RECOVER  = 3'd6;

  // bus phases
  localparam logic [4:0] S_IDLE          = 5'd0;
  localparam logic [4:0] S_RESET_LOW     = 5'd1;
  localparam logic [4:0] S_PRESENCE_WAIT = 5'd2;
  localparam logic [4:0] S_PRESENCE_HOLD = 5'd3;
  localparam logic [4:0] S_WRITE_SETUP   = 5'd4;
  localparam logic [4:0] S_WRITE_HOLD    = 5'd5;
  localparam logic [4:0] S_READ_LOW      = 5'd6;
  localparam logic [4:0] S_READ_SAMPLE   = 5'd7;
  localparam logic [4:0] S_READ_RECOVER  = 5'd8;
  localparam logic [4:0] S_DONE          = 5'd9;

  // script steps
  localparam logic [2:0] STEP_RESET_A  = 3'd0;
  localparam logic [2:0] STEP_SKIP_A   = 3'd1;
  localparam logic [2:0] STEP_CONVERT  = 3'd2;
  localparam logic [2:0] STEP_RESET_B  = 3'd3;
  localparam logic [2:0] STEP_SKIP_B   = 3'd4;
  localparam logic [2:0] STEP_READ_CMD = 3'd5;
  localparam logic [2:0] STEP_READ_LO  = 3'd6;
  localparam logic [2:0] STEP_READ_HI  = 3'd7;

  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  owtr_pkg::cfg_t timing;
  logic [4:0]     phase;
  logic [2:0]     step_idx;
  logic [2:0]     bit_idx;
  logic [15:0]    tick_cnt;
  logic [7:0]     shreg;
  logic [7:0]     temp_lo;
  logic [15:0]    temp_word;
  logic           no_presence;

  owtr_pkg::res_t expected_words[$];

  function automatic void clear_bus();
    timing.reset_low_ticks     = 16'd247;
    timing.presence_wait_ticks = 16'd27;
    timing.write_setup_ticks   = 8'd5;
    timing.write_hold_ticks    = 8'd20;
    timing.read_low_ticks      = 8'd1;
    timing.read_sample_ticks   = 8'd1;
    timing.read_recover_ticks  = 8'd17;
    phase       = S_IDLE;
    step_idx    = STEP_RESET_A;
    bit_idx     = '0;
    tick_cnt    = '0;
    shreg       = '0;
    temp_lo     = '0;
    temp_word   = '0;
    no_presence = 1'b0;
  endfunction

  function automatic void write_timing_reg(input logic [owtr_pkg::CfgIdxW-1:0] idx,
                                           input logic [owtr_pkg::CfgDataW-1:0] value);
    case (idx)
      REG_RESET_LOW:     timing.reset_low_ticks     = value;
      REG_PRESENCE_WAIT: timing.presence_wait_ticks = value;
      REG_WRITE_SETUP:   timing.write_setup_ticks   = value[7:0];
      REG_WRITE_HOLD:    timing.write_hold_ticks    = value[7:0];
      REG_READ_LOW:      timing.read_low_ticks      = value[7:0];
      REG_READ_SAMPLE:   timing.read_sample_ticks   = value[7:0];
      REG_READ_RECOVER:  timing.read_recover_ticks  = value[7:0];
      default: ;
    endcase
  endfunction

  // count one tick of the slot; a zero duration ends after one tick
  function automatic bit slot_elapsed(input logic [15:0] dur);
    tick_cnt = tick_cnt + 16'd1;
    if (tick_cnt >= dur || tick_cnt == 16'd0) begin
      tick_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void load_step();
    tick_cnt = '0;
    bit_idx  = '0;
    case (step_idx)
      STEP_RESET_A, STEP_RESET_B: phase = S_RESET_LOW;
      STEP_READ_LO, STEP_READ_HI: begin
        shreg = '0;
        phase = S_READ_LOW;
      end
      STEP_CONVERT: begin
        shreg = CMD_CONVERT;
        phase = S_WRITE_SETUP;
      end
      STEP_READ_CMD: begin
        shreg = CMD_READ_SCRATCH;
        phase = S_WRITE_SETUP;
      end
      default: begin
        shreg = CMD_SKIP_ROM;
        phase = S_WRITE_SETUP;
      end
    endcase
  endfunction

  function automatic void next_step();
    step_idx = step_idx + 3'd1;
    load_step();
  endfunction

  // a bus tick: drive/busy/done show the start state, the rest the end state
  function automatic owtr_pkg::res_t advance_bus(input logic line, input logic start);
    owtr_pkg::res_t r;
    logic drive;
    logic busy;
    logic done;
    drive = 1'b0;
    busy  = 1'b1;
    done  = 1'b0;
    case (phase)
      S_RESET_LOW: begin
        drive = 1'b1;
        if (slot_elapsed(timing.reset_low_ticks)) phase = S_PRESENCE_WAIT;
      end
      S_PRESENCE_WAIT: begin
        if (slot_elapsed(timing.presence_wait_ticks)) begin
          if (!line) begin
            phase = S_PRESENCE_HOLD;
          end else begin
            no_presence = 1'b1;
            next_step();
          end
        end
      end
      S_PRESENCE_HOLD: begin
        // wait for the sensor to let go of the line
        if (line) next_step();
      end
      S_WRITE_SETUP: begin
        drive = 1'b1;
        if (slot_elapsed({8'd0, timing.write_setup_ticks})) phase = S_WRITE_HOLD;
      end
      S_WRITE_HOLD: begin
        drive = ~shreg[0];
        if (slot_elapsed({8'd0, timing.write_hold_ticks})) begin
          shreg   = shreg >> 1;
          bit_idx = bit_idx + 3'd1;
          if (bit_idx == 3'd0) next_step();
          else phase = S_WRITE_SETUP;
        end
      end
      S_READ_LOW: begin
        drive = 1'b1;
        if (slot_elapsed({8'd0, timing.read_low_ticks})) phase = S_READ_SAMPLE;
      end
      S_READ_SAMPLE: begin
        if (slot_elapsed({8'd0, timing.read_sample_ticks})) begin
          if (line) shreg[bit_idx] = 1'b1;
          phase = S_READ_RECOVER;
        end
      end
      S_READ_RECOVER: begin
        if (slot_elapsed({8'd0, timing.read_recover_ticks})) begin
          bit_idx = bit_idx + 3'd1;
          if (bit_idx != 3'd0) begin
            phase = S_READ_LOW;
          end else if (step_idx == STEP_READ_LO) begin
            temp_lo = shreg;
            next_step();
          end else begin
            temp_word = {shreg, temp_lo};
            phase     = S_DONE;
          end
        end
      end
      S_DONE: begin
        busy  = 1'b0;
        done  = 1'b1;
        phase = S_IDLE;
      end
      default: begin
        busy  = 1'b0;
        phase = S_IDLE;
        if (start) begin
          no_presence = 1'b0;
          step_idx    = STEP_RESET_A;
          load_step();
        end
      end
    endcase
    r.drive_low        = drive;
    r.busy_res         = busy;
    r.done_res         = done;
    r.presence_missing = no_presence;
    r.temperature_raw  = temp_word;
    return r;
  endfunction

  function automatic int field_check(input string field, input logic [15:0] want,
                                     input logic [15:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    owtr_pkg::res_t want;
    if (!rst_n) begin
      clear_bus();
      expected_words.delete();
    end else begin
      if (cfg_we) write_timing_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready)
        expected_words.push_back(advance_bus(in_line_sample, in_start_request));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, got drive=%b busy=%b done=%b %s",
                   $time, out_drive_low, out_busy_res, out_done_res,
                   $sformatf("missing=%b temp=%h", out_presence_missing, out_temperature_raw));
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (want.done_res) begin
            temps_read++;
            if (want.presence_missing) presence_alerts++;
          end
          mismatches += field_check("drive_low", 16'(want.drive_low), 16'(out_drive_low));
          mismatches += field_check("busy_res", 16'(want.busy_res), 16'(out_busy_res));
          mismatches += field_check("done_res", 16'(want.done_res), 16'(out_done_res));
          mismatches += field_check("presence_missing", 16'(want.presence_missing),
                                    16'(out_presence_missing));
          mismatches += field_check("temperature_raw", want.temperature_raw,
                                    out_temperature_raw);
        end
      end
    end
    pending       = expected_words.size();
    seq_idle      = (phase == S_IDLE);
    seq_done_tick = (phase == S_DONE);
  end

endmodule

/* tb/one_wire_temperature_reader_tb.sv */
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_tb
// Drives bus ticks into the one-wire temperature reader under several timing
// settings: the defaults through the reset pulse and presence wait, all-zero
// slots, short random slots, and a stretch with the largest values, with
// random line levels, start requests and back-pressure. Long slots are cut
// short by retiming between ticks once the block has drained.
// Checking is done by owtr_tick_checker; this module makes stimulus and
// reports the verdict.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader_tb;

  import owtr_pkg::*;

  localparam int NUM_REGS       = 7;
  localparam int RANDOM_ITEMS   = 400;
  localparam int NUM_SETTINGS   = 3;
  localparam int DEFAULT_TICKS  = 285;
  localparam int LARGE_TICKS    = 100;
  localparam int MAX_GAP        = 5;
  localparam int HOLDOFF_AT     = 300;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int STALL_LIMIT    = 2000;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  owtr_in_if  in_ch ();
  owtr_out_if out_ch ();

  int   mismatches;
  int   pending;
  int   words_checked;
  int   temps_read;
  int   presence_alerts;
  logic seq_idle;
  logic seq_done_tick;

  bit gaps_on;
  int sent;
  int low_run;
  int timings_used;

  one_wire_temperature_reader u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  owtr_tick_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_ch.valid),
    .in_ready             (in_ch.ready),
    .in_line_sample       (in_ch.line_sample),
    .in_start_request     (in_ch.start_request),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_drive_low        (out_ch.drive_low),
    .out_busy_res         (out_ch.busy_res),
    .out_done_res         (out_ch.done_res),
    .out_presence_missing (out_ch.presence_missing),
    .out_temperature_raw  (out_ch.temperature_raw),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .mismatches           (mismatches),
    .pending              (pending),
    .words_checked        (words_checked),
    .temps_read           (temps_read),
    .presence_alerts      (presence_alerts),
    .seq_idle             (seq_idle),
    .seq_done_tick        (seq_done_tick)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // line level: mostly random, now and then held low for a stretch
  function automatic logic next_line();
    if (low_run > 0) begin
      low_run--;
      return 1'b0;
    end
    if ($urandom_range(0, 39) == 0) begin
      low_run = $urandom_range(4, 30);
      return 1'b0;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic cfg_t timing_between(input int lo, input int hi);
    cfg_t t;
    t.reset_low_ticks     = 16'($urandom_range(lo, hi));
    t.presence_wait_ticks = 16'($urandom_range(lo, hi));
    t.write_setup_ticks   = 8'($urandom_range(lo, hi));
    t.write_hold_ticks    = 8'($urandom_range(lo, hi));
    t.read_low_ticks      = 8'($urandom_range(lo, hi));
    t.read_sample_ticks   = 8'($urandom_range(lo, hi));
    t.read_recover_ticks  = 8'($urandom_range(lo, hi));
    return t;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(input logic line, input logic start);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.line_sample   <= line;
    in_ch.start_request <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // keep ticking until the sequencer is back in idle
  task automatic finish_sequence(input bit noisy);
    logic line;
    logic start;
    while (!seq_idle) begin
      line  = noisy ? next_line() : 1'b1;
      start = seq_done_tick ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
      send_tick(line, start);
    end
  endtask

  task automatic run_sequence();
    repeat ($urandom_range(0, 3)) send_tick(next_line(), 1'b0);
    send_tick(next_line(), 1'b1);
    finish_sequence(1'b1);
  endtask

  // write all timing registers once no word is in flight; unless mid_seq,
  // also wait for the sequencer to return to idle
  task automatic write_timing(input cfg_t t, input bit mid_seq);
    logic [CfgDataW-1:0] vals[NUM_REGS];
    vals[0] = t.reset_low_ticks;
    vals[1] = t.presence_wait_ticks;
    vals[2] = 16'(t.write_setup_ticks);
    vals[3] = 16'(t.write_hold_ticks);
    vals[4] = 16'(t.read_low_ticks);
    vals[5] = 16'(t.read_sample_ticks);
    vals[6] = 16'(t.read_recover_ticks);
    in_ch.valid <= 1'b0;
    while (pending != 0 || (!mid_seq && !seq_idle)) @(negedge clk);
    repeat (4) @(negedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    timings_used++;
  endtask

  // result side: random ready gaps plus one long hold-off
  initial begin : result_sink
    int gap;
    int taken;
    taken        = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (taken == HOLDOFF_AT) gap = HOLDOFF_CYCLES;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int budget;
    int loop_start;
    in_ch.valid         = 1'b0;
    in_ch.line_sample   = 1'b0;
    in_ch.start_request = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    gaps_on             = 1'b1;
    sent                = 0;
    low_run             = 0;
    timings_used        = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default timing: idle ticks, start, starts while busy are dropped,
    // then a released line through the reset pulse and presence wait (no
    // presence) into the first write slot
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    repeat (DEFAULT_TICKS) send_tick(1'b1, 1'b0);
    // shorten the slots for the rest of the script
    write_timing(timing_between(1, 2), 1'b1);
    finish_sequence(1'b0);

    // zero durations act as one tick; presence seen, then line held low
    write_timing('0, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (8) send_tick(1'b0, 1'b0);
    finish_sequence(1'b1);

    loop_start = sent;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0:       write_timing(timing_between(1, 1), 1'b0);
        1:       write_timing(timing_between(0, 3), 1'b0);
        default: write_timing(timing_between(1, 3), 1'b0);
      endcase
      gaps_on = (s != 2);
      budget  = loop_start + RANDOM_ITEMS * (s + 1) / NUM_SETTINGS;
      do run_sequence(); while (sent < budget);
    end

    // largest durations: a stretch of the reset pulse back to back, then
    // short slots to the end of the script
    gaps_on = 1'b0;
    write_timing('1, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (LARGE_TICKS) send_tick(next_line(), 1'b0);
    write_timing(timing_between(1, 2), 1'b1);
    finish_sequence(1'b1);
    gaps_on = 1'b1;

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Ran %0d bus ticks under %0d timing settings, %0d result words compared.",
             sent, timings_used, words_checked);
    $display("Completed %0d temperature reads, %0d with a missing presence pulse.",
             temps_read, presence_alerts);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
